FILE: design/kcl_pkg.sv
// shared types, key codes and helpers for the keypad combination lock
package kcl_pkg;

	localparam int ENTRY_W = 14;
	localparam int KEY_W   = 4;
	localparam int TRIES_W = 4;

	typedef logic [ENTRY_W-1:0] entry_t;
	typedef logic [KEY_W-1:0]   key_t;
	typedef logic [TRIES_W-1:0] tries_t;

	localparam key_t KEY_DIGIT_MIN = 4'd0;
	localparam key_t KEY_DIGIT_MAX = 4'd9;
	localparam key_t KEY_BACKSPACE = 4'd10;
	localparam key_t KEY_ENTER     = 4'd11;

	typedef enum logic [2:0] {
		OUT_NONE      = 3'd0,
		OUT_ACCEPTED  = 3'd1,
		OUT_REJECTED  = 3'd2,
		OUT_LOCKOUT   = 3'd3,
		OUT_ADMIN_OK  = 3'd4,
		OUT_ADMIN_BAD = 3'd5
	} outcome_t;

	typedef enum logic [1:0] {
		REG_USER_PASSWORD  = 2'd0,
		REG_ADMIN_PASSWORD = 2'd1,
		REG_MAX_TRIES      = 2'd2
	} reg_index_t;

	localparam tries_t MAX_TRIES_RESET = 4'd5;

	// reciprocal of ten, exact for every 14-bit dividend
	localparam int RECIP10       = 52429;
	localparam int RECIP10_SHIFT = 19;

	// largest entry value: 10^digits - 1, capped at the entry width
	function automatic longint entry_limit(input int digits);
		longint lim;
		lim = 1;
		for (int i = 0; i < digits; i++) begin
			lim = lim * 10;
		end
		lim = lim - 1;
		if (lim > (longint'(1) << ENTRY_W) - 1) begin
			lim = (longint'(1) << ENTRY_W) - 1;
		end
		return lim;
	endfunction

endpackage

FILE: design/keypad_combination_lock.sv
// Keypad combination lock: one key beat in, one result beat out. Each key is
// held in an input register, decoded against the entry, fail count and
// lockout state, and the result lands in an output register, so a key can
// be taken every cycle unless the output is stalled. The entry is limited
// to ENTRY_DIGITS decimal digits (and 14 bits); a digit that would overflow
// is dropped. Enter checks the user password in normal mode or the admin
// password while locked, and always clears the entry. Registers are
// written through the config channel, which is always ready; index 0 user
// password, 1 admin password, 2 try limit.
module keypad_combination_lock #(
	parameter int ENTRY_DIGITS = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  kcl_pkg::key_t         key_code,
	output logic                  out_valid,
	input  logic                  out_stall,
	output kcl_pkg::entry_t       entry_value,
	output kcl_pkg::outcome_t     outcome,
	output kcl_pkg::tries_t       wrong_count,
	output logic                  locked,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  kcl_pkg::reg_index_t   cfg_index,
	input  kcl_pkg::entry_t       cfg_data
);
	import kcl_pkg::*;

	localparam entry_t EntryLimit = ENTRY_W'(entry_limit(ENTRY_DIGITS));
	localparam int     ProdW      = ENTRY_W + 4;
	localparam int     RecipW     = ENTRY_W + 16;

	entry_t   user_pw_q, admin_pw_q;
	tries_t   max_tries_q;
	entry_t   entry_q;
	tries_t   fails_q;
	logic     lock_q;

	logic     valid_s1;
	key_t     key_s1;

	logic     valid_s2;
	entry_t   entry_s2;
	outcome_t outcome_s2;
	tries_t   fails_s2;
	logic     lock_s2;

	logic     out_free, fire_s1, accept;

	entry_t         entry_d;
	tries_t         fails_d, fails_inc;
	logic           lock_d;
	outcome_t       outcome_d;
	logic [ProdW-1:0]  append;
	logic [RecipW-1:0] recip;
	entry_t         entry_div10;

	assign out_free  = !valid_s2 || !out_stall;
	assign fire_s1   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_pw_q   <= '0;
			admin_pw_q  <= '0;
			max_tries_q <= MAX_TRIES_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_USER_PASSWORD:  user_pw_q   <= cfg_data;
				REG_ADMIN_PASSWORD: admin_pw_q  <= cfg_data;
				REG_MAX_TRIES:      max_tries_q <= cfg_data[TRIES_W-1:0];
				default: ;
			endcase
		end
	end

	// datapath for the key sitting in the input register
	always_comb begin
		append      = ProdW'(entry_q) * ProdW'(10) + ProdW'(key_s1);
		recip       = RecipW'(entry_q) * RecipW'(RECIP10);
		entry_div10 = ENTRY_W'(recip >> RECIP10_SHIFT);
		fails_inc   = fails_q + tries_t'(1);
		entry_d     = entry_q;
		fails_d     = fails_q;
		lock_d      = lock_q;
		outcome_d   = OUT_NONE;
		case (key_s1) inside
			[KEY_DIGIT_MIN:KEY_DIGIT_MAX]: begin
				if (append <= ProdW'(EntryLimit)) begin
					entry_d = append[ENTRY_W-1:0];
				end
			end
			KEY_BACKSPACE: begin
				entry_d = entry_div10;
			end
			KEY_ENTER: begin
				entry_d = '0;
				if (lock_q) begin
					if (entry_q == admin_pw_q) begin
						lock_d    = 1'b0;
						outcome_d = OUT_ADMIN_OK;
					end else begin
						outcome_d = OUT_ADMIN_BAD;
					end
				end else if (entry_q == user_pw_q) begin
					fails_d   = '0;
					outcome_d = OUT_ACCEPTED;
				end else if (fails_inc >= max_tries_q) begin
					fails_d   = '0;
					lock_d    = 1'b1;
					outcome_d = OUT_LOCKOUT;
				end else begin
					fails_d   = fails_inc;
					outcome_d = OUT_REJECTED;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			entry_q  <= '0;
			fails_q  <= '0;
			lock_q   <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire_s1) begin
				valid_s1 <= 1'b0;
			end
			if (fire_s1) begin
				valid_s2 <= 1'b1;
				entry_q  <= entry_d;
				fails_q  <= fails_d;
				lock_q   <= lock_d;
			end else if (out_free) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_s1 <= key_code;
		end
		if (fire_s1) begin
			entry_s2   <= entry_d;
			outcome_s2 <= outcome_d;
			fails_s2   <= fails_d;
			lock_s2    <= lock_d;
		end
	end

	assign out_valid   = valid_s2;
	assign entry_value = entry_s2;
	assign outcome     = outcome_s2;
	assign wrong_count = fails_s2;
	assign locked      = lock_s2;

`ifndef SYNTHESIS
	// the fail count is always zero while locked out
	a_locked_no_fails: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && locked |-> wrong_count == '0)
		else $error("wrong count nonzero while locked");

	// lockout begun must leave the lock set, admin unlock must clear it
	a_lock_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (outcome == OUT_LOCKOUT || outcome == OUT_ADMIN_OK)
		|-> locked == (outcome == OUT_LOCKOUT))
		else $error("lock flag disagrees with outcome");

	// any enter outcome clears the entry
	a_enter_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && outcome != OUT_NONE |-> entry_value == '0)
		else $error("entry not cleared after enter");

	// entry never exceeds the digit limit
	a_entry_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_value <= EntryLimit)
		else $error("entry beyond digit limit");
`endif

endmodule

FILE: test/tb_keypad_combination_lock.sv
// self-checking testbench for the keypad combination lock: keys, lockout and register writes
module tb_keypad_combination_lock;
	timeunit 1ns;
	timeprecision 1ps;
	import kcl_pkg::*;

	localparam int DIGITS = 4;
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 4;
	localparam int REPORT_LIMIT = 10;
	localparam key_t KEY_OTHER_LO = 4'd12;
	localparam key_t KEY_OTHER_HI = 4'd15;
	localparam reg_index_t REG_UNUSED = reg_index_t'(2'd3);

	typedef struct packed {
		entry_t   entry;
		outcome_t verdict;
		tries_t   misses;
		logic     lock;
	} lock_view_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	key_t       key_code = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	entry_t     entry_value;
	outcome_t   outcome;
	tries_t     wrong_count;
	logic       locked;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	reg_index_t cfg_index = REG_USER_PASSWORD;
	entry_t     cfg_data = '0;

	// lock state as the testbench sees it
	entry_t typed_value = '0;
	tries_t wrong_run = '0;
	logic   lock_held = 1'b0;
	entry_t user_code = '0;
	entry_t admin_code = '0;
	tries_t try_limit = MAX_TRIES_RESET;
	int     digit_cap;

	key_t       keys_pending[$];
	lock_view_t results_due[$];
	int keys_owed = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;
	int mismatches = 0;
	int keys_done = 0;
	int results_seen = 0;
	int writes_done = 0;
	int outcome_tally[8];

	keypad_combination_lock #(.ENTRY_DIGITS(DIGITS)) uut (.*);

	always #10 clk = ~clk;

	function automatic lock_view_t press(key_t k);
		lock_view_t v;
		logic [17:0] grown;
		tries_t bumped;
		v.verdict = OUT_NONE;
		if (k <= KEY_DIGIT_MAX) begin
			grown = 18'(typed_value) * 18'd10 + 18'(k);
			if (grown <= 18'(digit_cap)) begin
				typed_value = grown[ENTRY_W-1:0];
			end
		end else if (k == KEY_BACKSPACE) begin
			typed_value = typed_value / 10;
		end else if (k == KEY_ENTER) begin
			if (lock_held) begin
				if (typed_value == admin_code) begin
					lock_held = 1'b0;
					v.verdict = OUT_ADMIN_OK;
				end else begin
					v.verdict = OUT_ADMIN_BAD;
				end
			end else if (typed_value == user_code) begin
				wrong_run = '0;
				v.verdict = OUT_ACCEPTED;
			end else begin
				bumped = wrong_run + 1'b1;
				if (bumped >= try_limit) begin
					wrong_run = '0;
					lock_held = 1'b1;
					v.verdict = OUT_LOCKOUT;
				end else begin
					wrong_run = bumped;
					v.verdict = OUT_REJECTED;
				end
			end
			typed_value = '0;
		end
		v.entry = typed_value;
		v.misses = wrong_run;
		v.lock = lock_held;
		return v;
	endfunction

	// key driver: holds a beat while stalled, otherwise may go idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || !in_stall) begin
				if (keys_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					key_code <= keys_pending.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		out_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		lock_view_t seen;
		lock_view_t want;
		logic moved;
		moved = 1'b0;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				results_seen++;
				seen = '{entry_value, outcome, wrong_count, locked};
				if (!$isunknown(outcome)) begin
					outcome_tally[outcome]++;
				end
				if (results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("%t: stray result: entry %0d outcome %0d count %0d lock %b",
							$realtime, seen.entry, seen.verdict, seen.misses, seen.lock);
					end
				end else begin
					want = results_due.pop_front();
					if (seen.entry !== want.entry || seen.verdict !== want.verdict
						|| seen.misses !== want.misses || seen.lock !== want.lock) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display("%t: exp/got entry %0d/%0d outcome %0d/%0d",
								$realtime, want.entry, seen.entry, want.verdict,
								seen.verdict);
							$display("    count %0d/%0d lock %b/%b",
								want.misses, seen.misses, want.lock, seen.lock);
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				results_due.push_back(press(key_code));
				keys_owed--;
				keys_done++;
			end
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				writes_done++;
				case (cfg_index)
					REG_USER_PASSWORD: begin
						user_code = cfg_data;
					end
					REG_ADMIN_PASSWORD: begin
						admin_code = cfg_data;
					end
					REG_MAX_TRIES: begin
						try_limit = cfg_data[TRIES_W-1:0];
					end
					default: begin
					end
				endcase
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%t: no beat accepted for %0d cycles", $realtime, QUIET_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic push_key(key_t k);
		keys_pending.push_back(k);
		keys_owed++;
	endtask

	// digits of a value, sometimes with a leading zero
	task automatic type_value(int v);
		int digs[$];
		do begin
			digs.push_front(v % 10);
			v = v / 10;
		end while (v > 0);
		if ($urandom_range(3) == 0) begin
			digs.push_front(0);
		end
		foreach (digs[i]) begin
			push_key(key_t'(digs[i]));
		end
	endtask

	task automatic wait_idle();
		do @(posedge clk); while (keys_owed > 0 || results_due.size() > 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, entry_t val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(entry_t user, entry_t admin, entry_t tries, int idle, int stall,
		int count);
		int roll;
		int target;
		write_reg(REG_USER_PASSWORD, user);
		write_reg(REG_ADMIN_PASSWORD, admin);
		write_reg(REG_MAX_TRIES, tries);
		send_idle_pct = idle;
		stall_pct = stall;
		while (keys_pending.size() < count) begin
			roll = $urandom_range(99);
			if (roll < 10) begin
				repeat ($urandom_range(1, 3)) push_key(key_t'($urandom_range(15)));
			end else begin
				if (roll < 45) begin
					target = user;
				end else if (roll < 75) begin
					target = admin;
				end else begin
					target = $urandom_range(9999);
				end
				// typo corrected with backspace
				if ($urandom_range(9) == 0) begin
					push_key(key_t'($urandom_range(9)));
					push_key(KEY_BACKSPACE);
				end
				type_value(target);
				if ($urandom_range(9) == 0) begin
					push_key(key_t'($urandom_range(9)));
				end
				push_key(KEY_ENTER);
			end
		end
		wait_idle();
	endtask

	initial begin
		digit_cap = 1;
		for (int i = 0; i < DIGITS; i++) begin
			digit_cap = digit_cap * 10;
		end
		digit_cap = digit_cap - 1;
		if (digit_cap > (1 << ENTRY_W) - 1) begin
			digit_cap = (1 << ENTRY_W) - 1;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: empty entry matches, overflow, backspace, unknown keys
		push_key(KEY_ENTER);
		repeat (5) push_key(KEY_DIGIT_MAX);
		repeat (5) push_key(KEY_BACKSPACE);
		push_key(KEY_OTHER_LO);
		push_key(KEY_OTHER_HI);
		repeat (3) begin
			push_key(key_t'(3));
			push_key(KEY_ENTER);
		end
		wait_idle();

		// try limit lowered under the running count, then admin reject and unlock
		write_reg(REG_MAX_TRIES, 14'd2);
		write_reg(REG_ADMIN_PASSWORD, 14'd9876);
		push_key(key_t'(5));
		push_key(KEY_ENTER);
		push_key(KEY_ENTER);
		type_value(9876);
		push_key(KEY_ENTER);
		wait_idle();

		run_phase(14'd1234, 14'd9876, 14'd3, 0, 0, 80);
		run_phase(14'd0, 14'd9999, 14'd15, 59, 0, 80);
		run_phase(14'h3FFF, 14'd7, 14'd1, 0, 59, 80);
		write_reg(REG_UNUSED, 14'h2AAA);
		run_phase(14'd5, 14'd5, 14'd0, 8, 8, 80);
		run_phase(14'd42, 14'd31, 14'h3FF4, 0, 0, 80);

		$display("covered %0d keys, %0d results and %0d register writes over seven settings",
			keys_done, results_seen, writes_done);
		$display("outcomes: accepted %0d, rejected %0d, lockout %0d, unlock %0d, admin reject %0d",
			outcome_tally[OUT_ACCEPTED], outcome_tally[OUT_REJECTED], outcome_tally[OUT_LOCKOUT],
			outcome_tally[OUT_ADMIN_OK], outcome_tally[OUT_ADMIN_BAD]);
		if (mismatches == 0 && results_due.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
